/* rtl/canids_pkg.sv */
package canids_pkg;

  localparam int ID_W      = 29;
  localparam int DLC_W     = 4;
  localparam int DATA_W    = 64;
  localparam int BYTES     = 8;
  localparam int COUNT_W   = 32;
  localparam int IDX_W     = 6;
  localparam int USED_W    = 7;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ID_W-1:0]    id;
    logic               ext;
    logic [DLC_W-1:0]   dlc;
    logic [DATA_W-1:0]  data;
    logic [IDX_W-1:0]   idx;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               ext;
    logic [DLC_W-1:0]   dlc;
    logic [COUNT_W-1:0] count;
    logic [DATA_W-1:0]  last;
    logic [DATA_W-1:0]  mins;
    logic [DATA_W-1:0]  maxs;
  } entry_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   slot;
    logic [ID_W-1:0]    entry_id;
    logic               entry_extended;
    logic [DLC_W-1:0]   entry_dlc;
    logic [COUNT_W-1:0] entry_count;
    logic [DATA_W-1:0]  last_bytes;
    logic [DATA_W-1:0]  min_bytes;
    logic [DATA_W-1:0]  max_bytes;
    logic [USED_W-1:0]  entries_used;
    logic               dropped_new;
    logic               full_seen;
  } res_t;

  function automatic entry_t merge_entry(entry_t e, logic [DLC_W-1:0] dlc,
                                         logic [DATA_W-1:0] data);
    entry_t r;
    logic [7:0] d;
    r       = e;
    r.count = (e.count == COUNT_MAX) ? e.count : e.count + 1'b1;
    r.dlc   = dlc;
    r.last  = data;
    for (int b = 0; b < BYTES; b++) begin
      d = data[8*b +: 8];
      if (d < e.mins[8*b +: 8]) r.mins[8*b +: 8] = d;
      if (d > e.maxs[8*b +: 8]) r.maxs[8*b +: 8] = d;
    end
    return r;
  endfunction

endpackage

/* rtl/canids_if.sv */
interface canids_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [28:0] frame_id;
  logic        frame_extended;
  logic [3:0]  frame_dlc;
  logic [63:0] frame_data;
  logic [5:0]  entry_index;

  modport source (output valid, req_type, frame_id, frame_extended, frame_dlc,
                  frame_data, entry_index, input ready);
  modport sink   (input valid, req_type, frame_id, frame_extended, frame_dlc,
                  frame_data, entry_index, output ready);
endinterface

interface canids_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [5:0]  slot;
  logic [28:0] entry_id;
  logic        entry_extended;
  logic [3:0]  entry_dlc;
  logic [31:0] entry_count;
  logic [63:0] last_bytes;
  logic [63:0] min_bytes;
  logic [63:0] max_bytes;
  logic [6:0]  entries_used;
  logic        dropped_new;
  logic        full_seen;

  modport source (output valid, hit, slot, entry_id, entry_extended, entry_dlc,
                  entry_count, last_bytes, min_bytes, max_bytes, entries_used,
                  dropped_new, full_seen, input ready);
  modport sink   (input valid, hit, slot, entry_id, entry_extended, entry_dlc,
                  entry_count, last_bytes, min_bytes, max_bytes, entries_used,
                  dropped_new, full_seen, output ready);
endinterface

/* rtl/canids_front.sv */
module canids_front (
  canids_in_if.sink         in_ch,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output canids_pkg::cmd_t  cmd
);
  import canids_pkg::*;

  // A lookup searches standard identifiers only, so its key carries ext = 0.
  always_comb begin
    cmd.op   = op_t'(in_ch.req_type);
    cmd.id   = in_ch.frame_id;
    cmd.ext  = (cmd.op == OP_LOOKUP) ? 1'b0 : in_ch.frame_extended;
    cmd.dlc  = in_ch.frame_dlc;
    cmd.data = in_ch.frame_data;
    cmd.idx  = in_ch.entry_index;
  end

  assign cmd_valid   = in_ch.valid;
  assign in_ch.ready = cmd_ready;

endmodule

/* rtl/canids_queue.sv */
module canids_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  canids_pkg::cmd_t  wr_cmd,
  output logic              rd_valid,
  input  logic              rd_ready,
  output canids_pkg::cmd_t  rd_cmd
);
  import canids_pkg::*;

  cmd_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push, pop;

  assign wr_ready = (cnt_r != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slots_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slots_r[wptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

/* rtl/canids_engine.sv */
module canids_engine #(
  parameter int MAX_IDS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  canids_pkg::cmd_t  cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output canids_pkg::res_t  res
);
  import canids_pkg::*;

  localparam int IW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CW = $clog2(MAX_IDS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_RDW  = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  entry_t          mem [MAX_IDS];
  state_t          state_r, state_nxt;
  cmd_t            cmd_r;
  logic [CW-1:0]   used_r, used_nxt;
  logic            full_r, full_nxt;
  logic [CW-1:0]   issue_r, issue_nxt;
  entry_t          rd_data_r, ent_r;
  logic [IW-1:0]   rd_idx_r, slot_r, rd_addr;
  logic            rdv_r;
  res_t            res_r, res_nxt;
  logic            we;
  logic [IW-1:0]   wa;
  entry_t          wd, upd, fresh;
  logic            issuing, match, idx_ok, is_full;

  function automatic res_t mk_res(logic h, logic [IW-1:0] s, entry_t e,
                                  logic [CW-1:0] u, logic f, logic drop);
    res_t r;
    r = '0;
    if (h) begin
      r.hit            = 1'b1;
      r.slot           = IDX_W'(s);
      r.entry_id       = e.id;
      r.entry_extended = e.ext;
      r.entry_dlc      = e.dlc;
      r.entry_count    = e.count;
      r.last_bytes     = e.last;
      r.min_bytes      = e.mins;
      r.max_bytes      = e.maxs;
    end
    r.entries_used = USED_W'(u);
    r.dropped_new  = drop;
    r.full_seen    = f;
    return r;
  endfunction

  assign issuing = (state_r == S_SCAN) && (issue_r < used_r);
  assign match   = rdv_r && (rd_data_r.id == cmd_r.id) && (rd_data_r.ext == cmd_r.ext);
  assign idx_ok  = 32'(cmd_r.idx) < 32'(used_r);
  assign is_full = 32'(used_r) >= MAX_IDS;
  assign upd     = merge_entry(ent_r, cmd_r.dlc, cmd_r.data);

  always_comb begin
    fresh       = '0;
    fresh.id    = cmd_r.id;
    fresh.ext   = cmd_r.ext;
    fresh.dlc   = cmd_r.dlc;
    fresh.count = COUNT_W'(1);
    fresh.last  = cmd_r.data;
    fresh.mins  = cmd_r.data;
    fresh.maxs  = cmd_r.data;
  end

  assign rd_addr = (state_r == S_IDLE) ? IW'(cmd.idx) : issue_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    full_nxt  = full_r;
    issue_nxt = issue_r;
    res_nxt   = res_r;
    we        = 1'b0;
    wa        = slot_r;
    wd        = upd;
    case (state_r)
      S_IDLE: begin
        issue_nxt = '0;
        if (cmd_valid) begin
          case (cmd.op)
            OP_READ:  state_nxt = S_RDW;
            OP_CLEAR: begin
              used_nxt  = '0;
              full_nxt  = 1'b0;
              res_nxt   = mk_res(1'b0, '0, '0, '0, 1'b0, 1'b0);
              state_nxt = S_OUT;
            end
            default:  state_nxt = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (issuing) issue_nxt = issue_r + 1'b1;
        if (match) begin
          if (cmd_r.op == OP_RECORD) begin
            state_nxt = S_UPD;
          end else begin
            res_nxt   = mk_res(1'b1, rd_idx_r, rd_data_r, used_r, full_r, 1'b0);
            state_nxt = S_OUT;
          end
        end else if (!issuing && !rdv_r) begin
          state_nxt = S_OUT;
          if (cmd_r.op != OP_RECORD) begin
            res_nxt = mk_res(1'b0, '0, '0, used_r, full_r, 1'b0);
          end else if (is_full) begin
            full_nxt = 1'b1;
            res_nxt  = mk_res(1'b0, '0, '0, used_r, 1'b1, 1'b1);
          end else begin
            we       = 1'b1;
            wa       = used_r[IW-1:0];
            wd       = fresh;
            used_nxt = used_r + 1'b1;
            res_nxt  = mk_res(1'b1, used_r[IW-1:0], fresh, used_nxt, full_r, 1'b0);
          end
        end
      end
      S_RDW: begin
        res_nxt   = mk_res(idx_ok, rd_idx_r, rd_data_r, used_r, full_r, 1'b0);
        state_nxt = S_OUT;
      end
      S_UPD: begin
        we        = 1'b1;
        res_nxt   = mk_res(1'b1, slot_r, upd, used_r, full_r, 1'b0);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      full_r  <= 1'b0;
      rdv_r   <= 1'b0;
      issue_r <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      full_r  <= full_nxt;
      rdv_r   <= issuing && !match;
      issue_r <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_IDLE && cmd_valid) cmd_r <= cmd;
    if (match) begin
      ent_r  <= rd_data_r;
      slot_r <= rd_idx_r;
    end
  end

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res       = res_r;

endmodule

/* rtl/can_id_statistics_table_top.sv */
// Channel   Direction  Words carried
// in_ch     sink       one request: record, read by index, look up, clear
// out_ch    source     one result word for every request
//
// A request enters a two-word queue whenever the queue has room, so the input
// keeps moving while the table engine works or its result waits on out_ch.
// A word is written into a queue slot before the engine can take it.
// Record and look up walk the used entries through the table memory's single
// read port, one entry per cycle. Read by index goes through S_RDW to S_OUT,
// and clear goes straight from S_IDLE to S_OUT.
// Reset is synchronous and empties the table; no clearing pass is needed.
// Results stall in the output register while out_ch.ready is low.
module can_id_statistics_table_top #(
  parameter int MAX_IDS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  canids_in_if.sink     in_ch,
  canids_out_if.source  out_ch
);
  import canids_pkg::*;

  // Front side: the decoded request word and its handshake into the queue.
  cmd_t front_cmd, queue_cmd;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;
  res_t res;

  canids_front u_front (
    .in_ch     (in_ch),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // The queue decouples acceptance from the table walk.
  canids_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_cmd   (queue_cmd)
  );

  // Back side: searches, inserts, updates, clears and reports from the entry memory.
  canids_engine #(.MAX_IDS(MAX_IDS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  // The result word is a register inside the engine; this only fans it out.
  assign out_ch.hit            = res.hit;
  assign out_ch.slot           = res.slot;
  assign out_ch.entry_id       = res.entry_id;
  assign out_ch.entry_extended = res.entry_extended;
  assign out_ch.entry_dlc      = res.entry_dlc;
  assign out_ch.entry_count    = res.entry_count;
  assign out_ch.last_bytes     = res.last_bytes;
  assign out_ch.min_bytes      = res.min_bytes;
  assign out_ch.max_bytes      = res.max_bytes;
  assign out_ch.entries_used   = res.entries_used;
  assign out_ch.dropped_new    = res.dropped_new;
  assign out_ch.full_seen      = res.full_seen;

endmodule

/* rtl/canids_checker.sv */
module canids_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [5:0]  slot,
  input logic [31:0] entry_count,
  input logic [6:0]  entries_used,
  input logic        dropped_new,
  input logic        full_seen
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn before it was taken");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit |-> slot == 6'd0 && entry_count == 32'd0)
    else $error("miss reports entry data");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dropped_new |-> full_seen && !hit && entries_used != 7'd0)
    else $error("drop without a full table");

  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit |-> entry_count != 32'd0 && entries_used != 7'd0)
    else $error("hit on an empty entry");

endmodule

bind can_id_statistics_table_top canids_checker u_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .hit          (out_ch.hit),
  .slot         (out_ch.slot),
  .entry_count  (out_ch.entry_count),
  .entries_used (out_ch.entries_used),
  .dropped_new  (out_ch.dropped_new),
  .full_seen    (out_ch.full_seen)
);
